/* rtl/core/phcs_pkg.sv */
// ----------------------------------------------------------------------------
// phcs_pkg: shared types and constants of the consensus stream
// Fixed-point formats, register indexes, controller states and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package phcs_pkg;

    // Q1.F probability format
    localparam int PROB_FRAC_BITS = 16;
    localparam int PROB_W         = PROB_FRAC_BITS + 1;
    localparam int MAX_SYMBOLS    = 32;
    localparam int SYM_W          = 5;
    localparam int CNT_W          = 8;
    localparam int CFG_IDX_W      = 1;

    // occupancy accumulator, sum and product widths
    localparam int ACC_W  = PROB_W + 3;
    localparam int SUM_W  = ACC_W + 1;
    localparam int PROD_W = ACC_W + PROB_W;
    localparam int QM_W   = PROD_W - PROB_FRAC_BITS;

    // divider step counter (PROB_W quotient bits)
    localparam int DIV_CNT_W = $clog2(PROB_W);

    localparam logic [PROB_W-1:0]  ONE       = {1'b1, {PROB_FRAC_BITS{1'b0}}};
    localparam logic [PROB_W-1:0]  HALF      = {2'b01, {(PROB_FRAC_BITS-1){1'b0}}};
    localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
    localparam logic [SYM_W:0]     SYM_LIMIT = (SYM_W+1)'(MAX_SYMBOLS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELETE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_THR    = 1'b1;

    localparam logic [PROB_W-1:0]    UPPER_THR_RST        = HALF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_INS,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    // order of the shared-multiplier steps for the recurrence
    typedef enum logic [1:0] {
        MUL_M_MM,
        MUL_M_DM,
        MUL_D_MD,
        MUL_D_DD
    } t_mul_step;

    typedef enum logic [1:0] {
        DIV_MATCH,
        DIV_DELETE,
        DIV_COUNT
    } t_div_sel;

    typedef struct packed {
        logic      accept_emit;
        logic      accept_node;
        logic      mul_en;
        t_mul_step mul_step;
        logic      ins_en;
        logic      div_start;
        t_div_sel  div_sel;
        logic      div_take;
        logic      commit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_dp_status;

    function automatic logic [PROB_W-1:0] sat_one(input logic [QM_W-1:0] v);
        logic [PROB_W-1:0] r;
        r = (v > QM_W'(ONE)) ? ONE : v[PROB_W-1:0];
        return r;
    endfunction

endpackage

/* rtl/core/phcs_div.sv */
// ----------------------------------------------------------------------------
// phcs_div: iterative restoring divider
// Returns floor(X * 2^F / D) for X <= D, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module phcs_div
    import phcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_dividend,
    input  logic [SUM_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [PROB_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_count;
    logic [SUM_W:0]       r_rem;
    logic [SUM_W-1:0]     r_div;
    logic [PROB_W-1:0]    r_quo;

    logic [SUM_W:0] w_cand;
    logic           w_ge;

    // first step tests X itself (integer quotient bit), later steps shift
    assign w_cand = (r_count == '0) ? r_rem : {r_rem[SUM_W-1:0], 1'b0};
    assign w_ge   = (w_cand >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + 1'b1;
                if (r_count == DIV_CNT_W'(PROB_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend};
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_cand - {1'b0, r_div}) : w_cand;
            r_quo <= {r_quo[PROB_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/core/phcs_dp.sv */
// ----------------------------------------------------------------------------
// phcs_dp: consensus datapath
// Argmax tracking, recurrence state, shared multiplier, divider and the
// result register.
// ----------------------------------------------------------------------------
module phcs_dp
    import phcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_stat,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PROB_W-1:0]    i_cfg_data,
    // item fields
    input  logic [SYM_W-1:0]     i_symbol,
    input  logic [PROB_W-1:0]    i_emit_prob,
    input  logic [PROB_W-1:0]    i_begin_prob,
    input  logic [PROB_W-1:0]    i_t_mm,
    input  logic [PROB_W-1:0]    i_t_mi,
    input  logic [PROB_W-1:0]    i_t_md,
    input  logic [PROB_W-1:0]    i_t_dm,
    input  logic [PROB_W-1:0]    i_t_dd,
    input  logic [PROB_W-1:0]    i_t_ii,
    input  logic                 i_last_node,
    // result
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic                 o_match_is_consensus,
    output logic [SYM_W-1:0]     o_residue,
    output logic                 o_upper_case,
    output logic [CNT_W-1:0]     o_insert_count,
    output logic [PROB_W-1:0]    o_match_occupancy,
    output logic [PROB_W-1:0]    o_delete_occupancy
);

    // configuration
    logic [PROB_W-1:0] r_start_del;
    logic [PROB_W-1:0] r_upper_thr;

    // argmax of the current node
    logic              r_best_valid;
    logic [PROB_W-1:0] r_best_prob;
    logic [SYM_W-1:0]  r_best_sym;

    // state carried from node to node
    logic              r_first;
    logic [PROB_W-1:0] r_prev_m, r_prev_d, r_prev_i;
    logic [PROB_W-1:0] r_prev_tmm, r_prev_tmd, r_prev_tdm, r_prev_tdd;

    // node item held while it is worked on
    logic [PROB_W-1:0] r_bp, r_tmm, r_tmi, r_tmd, r_tdm, r_tdd, r_tii;
    logic              r_last;

    // intermediate results
    logic [ACC_W-1:0]  r_m_raw, r_d_raw;
    logic [PROB_W-1:0] r_ins, r_m_norm, r_d_norm;
    logic [CNT_W-1:0]  r_cnt;

    // result register
    logic              r_out_valid;
    logic              r_o_cons, r_o_upper;
    logic [SYM_W-1:0]  r_o_res;
    logic [CNT_W-1:0]  r_o_cnt;
    logic [PROB_W-1:0] r_o_m, r_o_d;

    logic [ACC_W-1:0]  w_mul_a;
    logic [PROB_W-1:0] w_mul_b;
    logic [PROD_W-1:0] w_prod;
    logic [QM_W-1:0]   w_qm;
    logic [SUM_W-1:0]  w_sum;
    logic [SUM_W-1:0]  w_div_x, w_div_d;
    logic              w_div_done;
    logic [PROB_W-1:0] w_quo;
    logic              w_tii_big;
    logic [PROB_W-1:0] w_cnt_den;
    logic [PROB_W-1:0] w_m_final, w_d_final;
    logic [CNT_W-1:0]  w_cnt_final;
    logic              w_better;
    logic              w_out_free;

    // ---- shared multiplier --------------------------------------------------
    always_comb begin
        w_mul_a = ACC_W'(r_prev_m);
        w_mul_b = r_prev_tmm;
        if (i_cmd.ins_en) begin
            w_mul_a = r_m_raw;
            w_mul_b = r_tmi;
        end else begin
            case (i_cmd.mul_step)
                MUL_M_MM: begin
                    w_mul_a = ACC_W'(r_prev_m);
                    w_mul_b = r_prev_tmm;
                end
                MUL_M_DM: begin
                    w_mul_a = ACC_W'(r_prev_d);
                    w_mul_b = r_prev_tdm;
                end
                MUL_D_MD: begin
                    w_mul_a = ACC_W'(r_prev_m);
                    w_mul_b = r_prev_tmd;
                end
                MUL_D_DD: begin
                    w_mul_a = ACC_W'(r_prev_d);
                    w_mul_b = r_prev_tdd;
                end
                default: begin
                    w_mul_a = ACC_W'(r_prev_m);
                    w_mul_b = r_prev_tmm;
                end
            endcase
        end
    end

    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    assign w_qm   = w_prod[PROD_W-1:PROB_FRAC_BITS];
    assign w_sum  = SUM_W'(r_m_raw) + SUM_W'(r_d_raw);

    // ---- divider operands ---------------------------------------------------
    assign w_tii_big = (r_tii >= ONE);
    assign w_cnt_den = w_tii_big ? PROB_W'(1) : (ONE - r_tii);

    always_comb begin
        case (i_cmd.div_sel)
            DIV_MATCH: begin
                w_div_x = SUM_W'(r_m_raw);
                w_div_d = w_sum;
            end
            DIV_DELETE: begin
                w_div_x = SUM_W'(r_d_raw);
                w_div_d = w_sum;
            end
            DIV_COUNT: begin
                w_div_x = SUM_W'(1);
                w_div_d = SUM_W'(w_cnt_den);
            end
            default: begin
                w_div_x = SUM_W'(1);
                w_div_d = SUM_W'(1);
            end
        endcase
    end

    phcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_div_x),
        .i_divisor  (w_div_d),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // ---- final values of the node -------------------------------------------
    always_comb begin
        if (r_first) begin
            w_m_final = r_m_raw[PROB_W-1:0];
            w_d_final = r_d_raw[PROB_W-1:0];
        end else if (w_sum == '0) begin
            w_m_final = '0;
            w_d_final = '0;
        end else begin
            w_m_final = r_m_norm;
            w_d_final = r_d_norm;
        end
        if (r_last || (r_ins < HALF)) begin
            w_cnt_final = '0;
        end else if (w_tii_big) begin
            w_cnt_final = CNT_MAX;
        end else begin
            w_cnt_final = r_cnt;
        end
    end

    assign w_better   = ({1'b0, i_symbol} < SYM_LIMIT) &&
                        (!r_best_valid || (i_emit_prob > r_best_prob));
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ---- configuration ------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_del <= '0;
            r_upper_thr <= UPPER_THR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_START_DELETE: r_start_del <= i_cfg_data;
                CFG_UPPER_THR:    r_upper_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---- argmax and carried state -------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
            r_best_prob  <= '0;
            r_best_sym   <= '0;
            r_first      <= 1'b1;
            r_prev_m     <= '0;
            r_prev_d     <= '0;
            r_prev_i     <= '0;
            r_prev_tmm   <= '0;
            r_prev_tmd   <= '0;
            r_prev_tdm   <= '0;
            r_prev_tdd   <= '0;
        end else if (i_cmd.commit) begin
            r_best_valid <= 1'b0;
            r_best_prob  <= '0;
            r_best_sym   <= '0;
            if (r_last) begin
                r_first    <= 1'b1;
                r_prev_m   <= '0;
                r_prev_d   <= '0;
                r_prev_i   <= '0;
                r_prev_tmm <= '0;
                r_prev_tmd <= '0;
                r_prev_tdm <= '0;
                r_prev_tdd <= '0;
            end else begin
                r_first    <= 1'b0;
                r_prev_m   <= w_m_final;
                r_prev_d   <= w_d_final;
                r_prev_i   <= r_ins;
                r_prev_tmm <= r_tmm;
                r_prev_tmd <= r_tmd;
                r_prev_tdm <= r_tdm;
                r_prev_tdd <= r_tdd;
            end
        end else if (i_cmd.accept_emit && w_better) begin
            r_best_valid <= 1'b1;
            r_best_prob  <= i_emit_prob;
            r_best_sym   <= i_symbol;
        end
    end

    // ---- node working registers ---------------------------------------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_node) begin
            r_bp   <= i_begin_prob;
            r_tmm  <= i_t_mm;
            r_tmi  <= i_t_mi;
            r_tmd  <= i_t_md;
            r_tdm  <= i_t_dm;
            r_tdd  <= i_t_dd;
            r_tii  <= i_t_ii;
            r_last <= i_last_node;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_step)
                MUL_M_MM: r_m_raw <= ACC_W'(w_qm) + ACC_W'(r_prev_i) + ACC_W'(r_bp);
                MUL_M_DM: r_m_raw <= r_m_raw + ACC_W'(w_qm);
                MUL_D_MD: r_d_raw <= ACC_W'(w_qm);
                MUL_D_DD: begin
                    if (r_first) begin
                        r_m_raw <= ACC_W'(sat_one(QM_W'(r_bp)));
                        r_d_raw <= ACC_W'(sat_one(QM_W'(r_start_del)));
                    end else begin
                        r_d_raw <= r_d_raw + ACC_W'(w_qm);
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.ins_en) begin
            r_ins <= r_last ? '0 : sat_one(w_qm);
        end
        if (i_cmd.div_take) begin
            case (i_cmd.div_sel)
                DIV_MATCH:  r_m_norm <= w_quo;
                DIV_DELETE: r_d_norm <= w_quo;
                DIV_COUNT:  r_cnt <= (w_quo > PROB_W'(CNT_MAX)) ? CNT_MAX : w_quo[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- result register ----------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_cons  <= (w_m_final >= HALF);
            r_o_res   <= r_best_sym;
            r_o_upper <= (r_best_prob >= r_upper_thr);
            r_o_cnt   <= w_cnt_final;
            r_o_m     <= w_m_final;
            r_o_d     <= w_d_final;
        end
    end

    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = w_out_free;

    assign o_out_valid          = r_out_valid;
    assign o_match_is_consensus = r_o_cons;
    assign o_residue            = r_o_res;
    assign o_upper_case         = r_o_upper;
    assign o_insert_count       = r_o_cnt;
    assign o_match_occupancy    = r_o_m;
    assign o_delete_occupancy   = r_o_d;

endmodule

/* rtl/core/phcs_ctrl.sv */
// ----------------------------------------------------------------------------
// phcs_ctrl: consensus controller
// Sequences the multiply steps, the three divisions and the result hand-off.
// ----------------------------------------------------------------------------
module phcs_ctrl
    import phcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_action,
    input  t_dp_status i_stat,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_action) begin
                    n_state = S_MUL;
                    n_step  = '0;
                end
            end
            S_MUL: begin
                n_step = r_step + 1'b1;
                if (t_mul_step'(r_step) == MUL_D_DD) begin
                    n_state = S_INS;
                end
            end
            S_INS: begin
                n_state = S_DIV_START;
                n_step  = '0;
            end
            S_DIV_START: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    if (t_div_sel'(r_step) == DIV_COUNT) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_DIV_START;
                        n_step  = r_step + 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd             = '0;
        o_cmd.mul_step    = t_mul_step'(r_step);
        o_cmd.div_sel     = t_div_sel'(r_step);
        o_in_stall        = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall        = 1'b0;
                o_cmd.accept_emit = i_in_valid && !i_action;
                o_cmd.accept_node = i_in_valid && i_action;
            end
            S_MUL:       o_cmd.mul_en    = 1'b1;
            S_INS:       o_cmd.ins_en    = 1'b1;
            S_DIV_START: o_cmd.div_start = 1'b1;
            S_DIV_WAIT:  o_cmd.div_take  = i_stat.div_done;
            S_OUT:       o_cmd.commit    = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

/* rtl/core/profile_hmm_consensus_stream.sv */
// ----------------------------------------------------------------------------
// profile_hmm_consensus_stream: streamed consensus of a profile HMM
// Tracks the argmax emission of each node, runs the forward occupancy
// recurrence on each node item and emits one consensus beat per node.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake               Beat
//  -------  ---------  ----------------------  ---------------------------------
//  in       sink       i_in_valid / o_in_stall  emission or node item
//  out      source     o_out_valid / i_out_stall one consensus result per node
//  cfg      sink       i_cfg_valid / o_cfg_ready register index and data
//
//  Emission beats are taken one per cycle while no node beat is in work. A
//  node beat, once taken, stalls the input through four steps on the shared
//  multiplier, one insert-occupancy product, then three divisions (start,
//  17 quotient-bit steps, done) on one iterative divider, and the load of
//  the result register.
//  i_rst_n is synchronous and active low; it clears the recurrence state,
//  the argmax and the registers (threshold resets to one half).
//  A stalled result holds in the output register while further emission
//  beats are taken; a node finishing into a full register waits for it.
//  The configuration port is always ready.
// ----------------------------------------------------------------------------
module profile_hmm_consensus_stream
    import phcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_action,
    input  logic [SYM_W-1:0]     i_symbol,
    input  logic [PROB_W-1:0]    i_emit_prob,
    input  logic [PROB_W-1:0]    i_begin_prob,
    input  logic [PROB_W-1:0]    i_t_mm,
    input  logic [PROB_W-1:0]    i_t_mi,
    input  logic [PROB_W-1:0]    i_t_md,
    input  logic [PROB_W-1:0]    i_t_dm,
    input  logic [PROB_W-1:0]    i_t_dd,
    input  logic [PROB_W-1:0]    i_t_ii,
    input  logic                 i_last_node,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_match_is_consensus,
    output logic [SYM_W-1:0]     o_residue,
    output logic                 o_upper_case,
    output logic [CNT_W-1:0]     o_insert_count,
    output logic [PROB_W-1:0]    o_match_occupancy,
    output logic [PROB_W-1:0]    o_delete_occupancy,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PROB_W-1:0]    i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_stat;

    // registers are plain flops, so a write never has to wait
    assign o_cfg_ready = 1'b1;

    phcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    phcs_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_stat               (w_stat),
        .i_cfg_we             (i_cfg_valid),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_symbol             (i_symbol),
        .i_emit_prob          (i_emit_prob),
        .i_begin_prob         (i_begin_prob),
        .i_t_mm               (i_t_mm),
        .i_t_mi               (i_t_mi),
        .i_t_md               (i_t_md),
        .i_t_dm               (i_t_dm),
        .i_t_dd               (i_t_dd),
        .i_t_ii               (i_t_ii),
        .i_last_node          (i_last_node),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_match_is_consensus (o_match_is_consensus),
        .o_residue            (o_residue),
        .o_upper_case         (o_upper_case),
        .o_insert_count       (o_insert_count),
        .o_match_occupancy    (o_match_occupancy),
        .o_delete_occupancy   (o_delete_occupancy)
    );

endmodule

/* test/tb_profile_hmm_consensus_stream.sv */
// ----------------------------------------------------------------------------
// tb_profile_hmm_consensus_stream: self-checking bench for the consensus stream
// Drives emission and node beats with random gaps, stalls the result channel
// at random and checks every consensus beat, field by field, against a
// cycle-free model of the occupancy recurrence and the argmax tracking.
// ----------------------------------------------------------------------------
module tb_profile_hmm_consensus_stream;
    import phcs_pkg::*;

    localparam logic ACT_EMIT    = 1'b0;
    localparam logic ACT_NODE    = 1'b1;
    localparam int   P_ONE       = 1 << PROB_FRAC_BITS;
    localparam int   QUIET_LIMIT = 2000;  // quiet spell that ends the run
    localparam int   DRAIN_WAIT  = 80;

    typedef struct packed {
        logic              action;
        logic [SYM_W-1:0]  symbol;
        logic [PROB_W-1:0] emit_prob;
        logic [PROB_W-1:0] begin_prob;
        logic [PROB_W-1:0] t_mm;
        logic [PROB_W-1:0] t_mi;
        logic [PROB_W-1:0] t_md;
        logic [PROB_W-1:0] t_dm;
        logic [PROB_W-1:0] t_dd;
        logic [PROB_W-1:0] t_ii;
        logic              last_node;
    } t_hmm_beat;

    typedef struct packed {
        logic              match_is_consensus;
        logic [SYM_W-1:0]  residue;
        logic              upper_case;
        logic [CNT_W-1:0]  insert_count;
        logic [PROB_W-1:0] match_occupancy;
        logic [PROB_W-1:0] delete_occupancy;
    } t_node_consensus;

    // clock, reset and DUT-facing drives
    logic              i_clk     = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    t_hmm_beat         in_beat   = '0;
    logic              out_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PROB_W-1:0] cfg_data  = '0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic              o_match_is_consensus;
    logic [SYM_W-1:0]  o_residue;
    logic              o_upper_case;
    logic [CNT_W-1:0]  o_insert_count;
    logic [PROB_W-1:0] o_match_occupancy;
    logic [PROB_W-1:0] o_delete_occupancy;
    logic              o_cfg_ready;

    t_hmm_beat         beats_to_send[$];
    t_node_consensus   consensus_due[$];

    int fail_cnt   = 0;
    int gap_left   = 0;
    bit in_burst   = 1'b0;
    int stall_left = 0;
    bit out_burst  = 1'b0;
    int quiet      = 0;

    // mirrored registers
    logic [PROB_W-1:0] cfg_start_delete = '0;
    logic [PROB_W-1:0] cfg_upper_thr    = UPPER_THR_RST;

    // model state: recurrence of the previous node and argmax of this one
    logic [PROB_W-1:0] occ_match  = '0;
    logic [PROB_W-1:0] occ_delete = '0;
    logic [PROB_W-1:0] occ_insert = '0;
    logic [PROB_W-1:0] tr_mm = '0, tr_md = '0, tr_dm = '0, tr_dd = '0;
    logic [PROB_W-1:0] top_prob   = '0;
    logic [SYM_W-1:0]  top_sym    = '0;
    bit                top_seen   = 1'b0;
    bit                model_start = 1'b1;

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> PROB_FRAC_BITS;
    endfunction

    function automatic logic [63:0] clip_one(input logic [63:0] v);
        return (v > 64'(ONE)) ? 64'(ONE) : v;
    endfunction

    // Advances the model by one accepted beat; a node beat queues its result.
    function automatic void step_profile(input t_hmm_beat b);
        logic [63:0] m_raw, d_raw, total, m, d, ins, cnt;
        t_node_consensus r;
        if (b.action == ACT_EMIT) begin
            // first maximum in arrival order wins
            if (b.symbol < MAX_SYMBOLS && (!top_seen || b.emit_prob > top_prob)) begin
                top_prob = b.emit_prob;
                top_sym  = b.symbol;
                top_seen = 1'b1;
            end
        end else begin
            if (model_start) begin
                m_raw = clip_one(64'(b.begin_prob));
                m     = m_raw;
                d     = clip_one(64'(cfg_start_delete));
            end else begin
                m_raw = q_mul(64'(occ_match), 64'(tr_mm)) + 64'(occ_insert)
                      + q_mul(64'(occ_delete), 64'(tr_dm)) + 64'(b.begin_prob);
                d_raw = q_mul(64'(occ_match), 64'(tr_md))
                      + q_mul(64'(occ_delete), 64'(tr_dd));
                total = m_raw + d_raw;
                // both normalised by the same sum, taken before either changes
                if (total == 64'd0) begin
                    m = 64'd0;
                    d = 64'd0;
                end else begin
                    m = clip_one((m_raw << PROB_FRAC_BITS) / total);
                    d = clip_one((d_raw << PROB_FRAC_BITS) / total);
                end
            end
            ins = b.last_node ? 64'd0 : clip_one(q_mul(m_raw, 64'(b.t_mi)));
            cnt = 64'd0;
            if (!b.last_node && ins >= 64'(HALF)) begin
                if (b.t_ii >= ONE)
                    cnt = 64'(CNT_MAX);
                else
                    cnt = 64'(ONE) / (64'(ONE) - 64'(b.t_ii));
                if (cnt > 64'(CNT_MAX))
                    cnt = 64'(CNT_MAX);
            end
            r.match_is_consensus = (m >= 64'(HALF));
            r.residue            = top_sym;
            r.upper_case         = (top_prob >= cfg_upper_thr);
            r.insert_count       = cnt[CNT_W-1:0];
            r.match_occupancy    = m[PROB_W-1:0];
            r.delete_occupancy   = d[PROB_W-1:0];
            consensus_due.push_back(r);

            top_prob = '0;
            top_sym  = '0;
            top_seen = 1'b0;
            if (b.last_node) begin
                // model ends: next node starts afresh
                occ_match   = '0;
                occ_delete  = '0;
                occ_insert  = '0;
                tr_mm = '0; tr_md = '0; tr_dm = '0; tr_dd = '0;
                model_start = 1'b1;
            end else begin
                occ_match   = m[PROB_W-1:0];
                occ_delete  = d[PROB_W-1:0];
                occ_insert  = ins[PROB_W-1:0];
                tr_mm = b.t_mm; tr_md = b.t_md; tr_dm = b.t_dm; tr_dd = b.t_dd;
                model_start = 1'b0;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [PROB_W-1:0] pick_prob();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ONE;
            2:       return HALF;
            3:       return PROB_W'($urandom_range(P_ONE - 16, P_ONE));
            default: return PROB_W'($urandom_range(0, P_ONE));
        endcase
    endfunction

    // insert self-loop: leans towards values near one for large counts
    function automatic logic [PROB_W-1:0] pick_loop();
        case ($urandom_range(0, 4))
            0:       return PROB_W'($urandom_range(0, P_ONE));
            1:       return PROB_W'($urandom_range(P_ONE - 3000, P_ONE - 1));
            2:       return PROB_W'($urandom_range(P_ONE / 2, P_ONE));
            3:       return ONE;
            default: return pick_prob();
        endcase
    endfunction

    // fields a beat does not use carry random values
    function automatic t_hmm_beat noise_beat();
        t_hmm_beat b;
        b.action     = ACT_EMIT;
        b.symbol     = SYM_W'($urandom_range(0, MAX_SYMBOLS - 1));
        b.emit_prob  = pick_prob();
        b.begin_prob = pick_prob();
        b.t_mm       = pick_prob();
        b.t_mi       = pick_prob();
        b.t_md       = pick_prob();
        b.t_dm       = pick_prob();
        b.t_dd       = pick_prob();
        b.t_ii       = pick_prob();
        b.last_node  = 1'($urandom_range(0, 1));
        return b;
    endfunction

    function automatic void push_emit(input int sym, input logic [PROB_W-1:0] p);
        t_hmm_beat b;
        b           = noise_beat();
        b.action    = ACT_EMIT;
        b.symbol    = SYM_W'(sym);
        b.emit_prob = p;
        beats_to_send.push_back(b);
    endfunction

    function automatic void push_node(input logic [PROB_W-1:0] bp, input logic [PROB_W-1:0] tmm,
                                      input logic [PROB_W-1:0] tmi, input logic [PROB_W-1:0] tmd,
                                      input logic [PROB_W-1:0] tdm, input logic [PROB_W-1:0] tdd,
                                      input logic [PROB_W-1:0] tii, input bit last);
        t_hmm_beat b;
        b            = noise_beat();
        b.action     = ACT_NODE;
        b.begin_prob = bp;
        b.t_mm       = tmm;
        b.t_mi       = tmi;
        b.t_md       = tmd;
        b.t_dm       = tdm;
        b.t_dd       = tdd;
        b.t_ii       = tii;
        b.last_node  = last;
        beats_to_send.push_back(b);
    endfunction

    // One node: emissions over a whole alphabet in order, or a few scattered
    // ones, then the closing node beat. Returns the number of beats queued.
    function automatic int queue_node(input bit last);
        int n, k, alpha, sel;
        logic [PROB_W-1:0] p, prev_p, bp, tmm, tmi, tdm;
        n      = 0;
        prev_p = '0;
        sel    = $urandom_range(0, 9);
        alpha  = (sel < 4) ? 4 : (sel < 7) ? 20 : (sel == 7) ? MAX_SYMBOLS : 0;
        if (alpha == 0)
            k = $urandom_range(0, 8);
        else
            k = alpha;
        for (int s = 0; s < k; s++) begin
            // repeated values exercise the first-maximum rule
            p      = ($urandom_range(0, 5) == 0) ? prev_p : pick_prob();
            prev_p = p;
            push_emit((alpha == 0) ? $urandom_range(0, MAX_SYMBOLS - 1) : s, p);
            n++;
        end
        if ($urandom_range(0, 4) != 0) begin
            // well-formed node: outgoing transitions sum to one
            tmm = PROB_W'($urandom_range(0, P_ONE));
            tmi = PROB_W'($urandom_range(0, P_ONE - int'(tmm)));
            tdm = PROB_W'($urandom_range(0, P_ONE));
            bp  = ($urandom_range(0, 3) != 0) ? PROB_W'($urandom_range(0, P_ONE / 8))
                                              : pick_prob();
            push_node(bp, tmm, tmi, ONE - tmm - tmi, tdm, ONE - tdm, pick_loop(), last);
        end else begin
            push_node(pick_prob(), pick_prob(), pick_prob(), pick_prob(),
                      pick_prob(), pick_prob(), pick_loop(), last);
        end
        return n + 1;
    endfunction

    function automatic int queue_model();
        int n, nodes;
        n     = 0;
        nodes = $urandom_range(1, 8);
        for (int i = 0; i < nodes; i++)
            n += queue_node(i == nodes - 1);
        return n;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // DUT
    // ------------------------------------------------------------------
    profile_hmm_consensus_stream DUT (
        .i_clk                (i_clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_stall           (o_in_stall),
        .i_action             (in_beat.action),
        .i_symbol             (in_beat.symbol),
        .i_emit_prob          (in_beat.emit_prob),
        .i_begin_prob         (in_beat.begin_prob),
        .i_t_mm               (in_beat.t_mm),
        .i_t_mi               (in_beat.t_mi),
        .i_t_md               (in_beat.t_md),
        .i_t_dm               (in_beat.t_dm),
        .i_t_dd               (in_beat.t_dd),
        .i_t_ii               (in_beat.t_ii),
        .i_last_node          (in_beat.last_node),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (out_stall),
        .o_match_is_consensus (o_match_is_consensus),
        .o_residue            (o_residue),
        .o_upper_case         (o_upper_case),
        .o_insert_count       (o_insert_count),
        .o_match_occupancy    (o_match_occupancy),
        .o_delete_occupancy   (o_delete_occupancy),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (cfg_index),
        .i_cfg_data           (cfg_data)
    );

    // ------------------------------------------------------------------
    // Input driver: a beat is held until taken, then the next one follows
    // after its drawn gap. Bursts with no gaps come and go at random.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_in
        logic      taken;
        t_hmm_beat nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            taken = in_valid && !o_in_stall;
            if (taken)
                step_profile(in_beat);
            if (in_valid && !taken) begin
                // stalled: payload holds
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (beats_to_send.size() > 0) begin
                nxt      = beats_to_send.pop_front();
                in_beat  <= nxt;
                in_valid <= 1'b1;
                gap_left <= in_burst ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 31) == 0)
                    in_burst <= !in_burst;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: after each beat taken, the next result is stalled for
    // a drawn number of its valid cycles, so stalls meet a live result.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_out
        t_node_consensus want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (consensus_due.size() == 0) begin
                    $error("consensus beat with nothing expected");
                    fail_cnt++;
                end else begin
                    want = consensus_due.pop_front();
                    check_field("match_is_consensus", 64'(want.match_is_consensus),
                                64'(o_match_is_consensus));
                    check_field("residue", 64'(want.residue), 64'(o_residue));
                    check_field("upper_case", 64'(want.upper_case), 64'(o_upper_case));
                    check_field("insert_count", 64'(want.insert_count),
                                64'(o_insert_count));
                    check_field("match_occupancy", 64'(want.match_occupancy),
                                64'(o_match_occupancy));
                    check_field("delete_occupancy", 64'(want.delete_occupancy),
                                64'(o_delete_occupancy));
                end
                stall_left = out_burst ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 15) == 0)
                    out_burst = !out_burst;
            end else if (o_out_valid && stall_left > 0) begin
                stall_left--;
            end
            out_stall <= (stall_left > 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any beat on any channel ends the run
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PROB_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_START_DELETE)
            cfg_start_delete = val;
        else if (idx == CFG_UPPER_THR)
            cfg_upper_thr = val;
        cfg_valid <= 1'b0;
    endtask

    // all beats sent, all results back, then let a trailing node beat finish
    task automatic settle();
        while (beats_to_send.size() != 0 || in_valid || consensus_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        int n;
        logic [PROB_W-1:0] sdp_set[5];
        logic [PROB_W-1:0] thr_set[5];

        // register settings per random phase: both extremes, then over-range
        // start delete with the nucleic threshold, then random
        sdp_set = '{17'd0, ONE, 17'h1FFFF, PROB_W'($urandom_range(0, P_ONE)),
                    PROB_W'($urandom_range(0, P_ONE))};
        thr_set = '{17'd0, ONE, 17'd58982, PROB_W'($urandom_range(0, P_ONE)),
                    PROB_W'($urandom_range(0, P_ONE))};

        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, reset register values.
        // First node with no emissions; begin above one saturates; full
        // insert occupancy with a self-loop of one gives the saturated count.
        push_node(17'h1FFFF, 17'd0, ONE, 17'd0, 17'd0, 17'd0, ONE, 1'b0);
        // tie on the maximum: the earlier symbol wins; all flow from insert
        push_emit(0, 17'd100);
        push_emit(1, ONE);
        push_emit(2, ONE);
        push_emit(31, 17'd0);
        push_node(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 1'b0);
        // symbols out of order; nothing flows in: zero sum
        push_emit(5, 17'd300);
        push_emit(2, 17'd300);
        push_emit(9, 17'd200);
        push_node(17'd0, ONE, 17'd0, ONE, ONE, ONE, 17'h1FFFF, 1'b0);
        // last node: no insert count despite a full insert transition
        push_emit(31, ONE);
        push_emit(30, ONE - 17'd1);
        push_node(17'd40000, HALF, ONE, HALF, ONE, 17'd0, ONE - 17'd1, 1'b1);
        // new model: match exactly one half, best exactly at threshold
        push_emit(0, HALF);
        push_node(HALF, ONE, ONE, 17'd0, 17'd0, ONE, ONE - 17'd1, 1'b0);
        // occupancy above one clips; count of four
        push_node(17'd1000, 17'd0, ONE, 17'd0, 17'd0, 17'd0, 17'd49152, 1'b0);
        push_node(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 1'b1);
        settle();

        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_START_DELETE, sdp_set[ph]);
            write_reg(CFG_UPPER_THR, thr_set[ph]);
            @(negedge i_clk);
            n = 0;
            while (n < 110)
                n += queue_model();
            settle();
        end

        if (fail_cnt == 0 && consensus_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
